>>> rtl/tnsg_pkg.sv
`default_nettype none

package tnsg_pkg;

  typedef enum logic [1:0] {
    CMD_TONE   = 2'd0,
    CMD_ATTEN  = 2'd1,
    CMD_NOISE  = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ADD  = 2'd1,
    ST_TICK = 2'd2,
    ST_DONE = 2'd3
  } state_e;

  localparam logic [1:0]  REG_CLOCK_STEP = 2'd0;
  localparam logic [1:0]  REG_TICK_COST  = 2'd1;

  localparam logic [1:0]  NOISE_CH       = 2'd3;
  localparam logic [15:0] SEED_WORD      = 16'h8000;
  localparam logic [10:0] PERIOD_ZERO_AS = 11'd1024;
  localparam logic [23:0] COST_FLOOR     = 24'd16;
  localparam logic [23:0] CLOCK_STEP_RST = 24'd3579545;
  localparam logic [23:0] TICK_COST_RST  = 24'd705600;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;         // apply a register-write command this cycle
    logic add_step;      // residue += clock_step
    logic tick;          // pay one tick and advance all counters
    logic latch_sample;  // capture mixed sample
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tick_due;      // residue >= effective tick cost
  } dp_status_t;

  function automatic logic [10:0] reload_of(input logic [9:0] p);
    return (p == 10'd0) ? PERIOD_ZERO_AS : {1'b0, p};
  endfunction

  function automatic logic [10:0] noise_reload(input logic [1:0] rate, input logic [9:0] p2);
    logic [10:0] r;
    case (rate)
      2'd0:    r = 11'h010;
      2'd1:    r = 11'h020;
      2'd2:    r = 11'h040;
      default: r = reload_of(p2);
    endcase
    return r;
  endfunction

  function automatic logic [12:0] amp_of(input logic [3:0] att);
    logic [12:0] a;
    case (att)
      4'd0:    a = 13'd4096;
      4'd1:    a = 13'd3254;
      4'd2:    a = 13'd2584;
      4'd3:    a = 13'd2053;
      4'd4:    a = 13'd1631;
      4'd5:    a = 13'd1295;
      4'd6:    a = 13'd1029;
      4'd7:    a = 13'd817;
      4'd8:    a = 13'd649;
      4'd9:    a = 13'd516;
      4'd10:   a = 13'd410;
      4'd11:   a = 13'd325;
      4'd12:   a = 13'd258;
      4'd13:   a = 13'd205;
      4'd14:   a = 13'd163;
      default: a = 13'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tnsg_ctrl.sv
`default_nettype none

module tnsg_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  input  wire logic [1:0]             command_i,
  input  wire tnsg_pkg::dp_status_t   status_i,
  output      logic                   busy,
  output      logic                   sample_valid_o,
  output      tnsg_pkg::dp_cmd_t      cmd_o
);
  import tnsg_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_e'(command_i) == CMD_SAMPLE)) state_d = ST_ADD;
      end
      ST_ADD:  state_d = ST_TICK;
      ST_TICK: begin
        if (!status_i.tick_due) state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    busy           = 1'b1;
    sample_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd_o.wr_en = accept && (cmd_e'(command_i) != CMD_SAMPLE);
      end
      ST_ADD:  cmd_o.add_step = 1'b1;
      ST_TICK: begin
        cmd_o.tick         = status_i.tick_due;
        cmd_o.latch_sample = !status_i.tick_due;
      end
      ST_DONE: sample_valid_o = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  a_done_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |=> !sample_valid_o && !busy)
    else $error("sample strobe not a single beat");

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_SAMPLE)) |=> (state_q == ST_ADD))
    else $error("sample command did not start the tick loop");

  a_write_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i != CMD_SAMPLE)) |=> !busy && !sample_valid_o)
    else $error("write command produced work beyond one cycle");

  a_latch_only_when_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch_sample |-> !cmd_o.tick && (state_q == ST_TICK))
    else $error("sample latched while ticks still due");

endmodule

`default_nettype wire

>>> rtl/tnsg_dp.sv
`default_nettype none

module tnsg_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [23:0]            cfg_wdata_i,
  input  wire logic [1:0]             command_i,
  input  wire logic [1:0]             channel_i,
  input  wire logic [9:0]             data_value_i,
  input  wire logic                   noise_white_i,
  input  wire logic [1:0]             noise_rate_i,
  input  wire tnsg_pkg::dp_cmd_t      cmd_i,
  output      tnsg_pkg::dp_status_t   status_o,
  output      logic signed [15:0]     sample_o
);
  import tnsg_pkg::*;

  logic [23:0] clock_step_q, tick_cost_q;
  logic [23:0] cost;

  logic [9:0]  period_q [3], period_d [3];
  logic [10:0] tone_cnt_q [3], tone_cnt_d [3];
  logic [10:0] tone_dec [3];
  logic [2:0]  tone_lvl_q, tone_lvl_d;
  logic [3:0]  atten_q [4], atten_d [4];
  logic        white_q, white_d;
  logic [1:0]  rate_q, rate_d;
  logic [10:0] noise_cnt_q, noise_cnt_d, noise_dec;
  logic [15:0] lfsr_q, lfsr_d;
  logic        noise_lvl_q, noise_lvl_d, fb;
  logic [24:0] residue_q, residue_d;

  logic [3:0]         levels;
  logic signed [16:0] term [4];
  logic signed [16:0] mix;
  logic signed [15:0] sat, sample_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_step_q <= CLOCK_STEP_RST;
      tick_cost_q  <= TICK_COST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CLOCK_STEP: clock_step_q <= cfg_wdata_i;
        REG_TICK_COST:  tick_cost_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cost              = (tick_cost_q < COST_FLOOR) ? COST_FLOOR : tick_cost_q;
  assign status_o.tick_due = (residue_q >= {1'b0, cost});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tone_dec[i] = (tone_cnt_q[i] != 11'd0) ? tone_cnt_q[i] - 11'd1 : 11'd0;
    end
    noise_dec = (noise_cnt_q != 11'd0) ? noise_cnt_q - 11'd1 : 11'd0;
    fb = white_q ? (lfsr_q[0] ^ lfsr_q[3]) : lfsr_q[0];
  end

  always_comb begin
    period_d    = period_q;
    tone_cnt_d  = tone_cnt_q;
    tone_lvl_d  = tone_lvl_q;
    atten_d     = atten_q;
    white_d     = white_q;
    rate_d      = rate_q;
    noise_cnt_d = noise_cnt_q;
    lfsr_d      = lfsr_q;
    noise_lvl_d = noise_lvl_q;
    residue_d   = residue_q;

    if (cmd_i.wr_en) begin
      case (cmd_e'(command_i))
        CMD_TONE: begin
          if (channel_i != NOISE_CH) period_d[channel_i] = data_value_i;
        end
        CMD_ATTEN: atten_d[channel_i] = data_value_i[3:0];
        CMD_NOISE: begin
          white_d     = noise_white_i;
          rate_d      = noise_rate_i;
          lfsr_d      = SEED_WORD;
          noise_lvl_d = 1'b1;
          noise_cnt_d = noise_reload(noise_rate_i, period_q[2]);
        end
        default: ;
      endcase
    end

    if (cmd_i.add_step) begin
      residue_d = residue_q + {1'b0, clock_step_q};
    end

    if (cmd_i.tick) begin
      residue_d = residue_q - {1'b0, cost};
      for (int i = 0; i < 3; i++) begin
        if (tone_dec[i] == 11'd0) begin
          tone_cnt_d[i] = reload_of(period_q[i]);
          tone_lvl_d[i] = ~tone_lvl_q[i];
        end else begin
          tone_cnt_d[i] = tone_dec[i];
        end
      end
      if (noise_dec == 11'd0) begin
        noise_cnt_d = noise_reload(rate_q, period_q[2]);
        lfsr_d      = {fb, lfsr_q[15:1]};
        noise_lvl_d = lfsr_q[1];
      end else begin
        noise_cnt_d = noise_dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        period_q[i]   <= 10'd0;
        tone_cnt_q[i] <= 11'd1;
      end
      for (int i = 0; i < 4; i++) begin
        atten_q[i] <= 4'hF;
      end
      tone_lvl_q  <= 3'b000;
      white_q     <= 1'b1;
      rate_q      <= 2'd2;
      noise_cnt_q <= 11'd64;
      lfsr_q      <= SEED_WORD;
      noise_lvl_q <= 1'b1;
      residue_q   <= 25'd0;
    end else begin
      period_q    <= period_d;
      tone_cnt_q  <= tone_cnt_d;
      tone_lvl_q  <= tone_lvl_d;
      atten_q     <= atten_d;
      white_q     <= white_d;
      rate_q      <= rate_d;
      noise_cnt_q <= noise_cnt_d;
      lfsr_q      <= lfsr_d;
      noise_lvl_q <= noise_lvl_d;
      residue_q   <= residue_d;
    end
  end

  assign levels = {noise_lvl_q, tone_lvl_q};

  // mixer: +/- amplitude per channel, then clamp to 16 bits
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      term[i] = levels[i] ? $signed({4'b0000, amp_of(atten_q[i])})
                          : -$signed({4'b0000, amp_of(atten_q[i])});
    end
    mix = term[0] + term[1] + term[2] + term[3];
    if (mix > 17'sd32767) begin
      sat = 16'sh7FFF;
    end else if (mix < -17'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = mix[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_sample) sample_q <= sat;
  end

  assign sample_o = sample_q;

  a_tone_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tone_cnt_q[0] != 11'd0) && (tone_cnt_q[1] != 11'd0) && (tone_cnt_q[2] != 11'd0))
    else $error("tone counter reached zero without reload");

  a_noise_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_cnt_q != 11'd0)
    else $error("noise counter reached zero without reload");

  a_tick_pays_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick |=> (residue_q == $past(residue_q) - {1'b0, $past(cost)}))
    else $error("tick did not pay the tick cost");

endmodule

`default_nettype wire

>>> rtl/tone_noise_sound_generator_unit.sv
`default_nettype none

// Three square-tone channels and one noise channel mixed to a signed 16-bit
// sample. A write command (tone period, attenuation, noise control) leaves
// busy low, and the next command may follow at once. A sample command adds
// clock_step to the residue, then runs N = floor((residue + clock_step) /
// cost) generator ticks, one tick per cycle in the tick loop, and latches the
// mixed sample, with busy high throughout; with the reset register values N is
// 5 or 6. The sample is presented on sample_o with sample_valid_o high for one
// cycle, and must be taken then: the receiver cannot stall. Registers are to
// be written through cfg_we_i/cfg_idx_i/cfg_wdata_i only while busy is low;
// the user is bound to this, and the block itself does not enforce it.
module tone_noise_sound_generator_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [23:0]        cfg_wdata_i,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [1:0]         command_i,
  input  wire logic [1:0]         channel_i,
  input  wire logic [9:0]         data_value_i,
  input  wire logic               noise_white_i,
  input  wire logic [1:0]         noise_rate_i,
  output      logic               sample_valid_o,
  output      logic signed [15:0] sample_o
);
  import tnsg_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  tnsg_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .command_i      (command_i),
    .status_i       (dp_status),
    .busy           (busy),
    .sample_valid_o (sample_valid_o),
    .cmd_o          (dp_cmd)
  );

  tnsg_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .command_i     (command_i),
    .channel_i     (channel_i),
    .data_value_i  (data_value_i),
    .noise_white_i (noise_white_i),
    .noise_rate_i  (noise_rate_i),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .sample_o      (sample_o)
  );

endmodule

`default_nettype wire
